// File: rtl/core/lbs_pkg.sv
// Package for the LED breathing sequencer: shared types, codes and sizes.
// No dependencies; used by every module in rtl/core.
package lbs_pkg;

    localparam int DEVICES_DEF = 2;
    localparam int SLOTS_DEF   = 4;
    localparam int MAX_RESULTS = 8;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    localparam logic [1:0] RES_STATUS = 2'd0;
    localparam logic [1:0] RES_OFF    = 2'd1;
    localparam logic [1:0] RES_DUTY   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_DEV = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_SERVING = 2'd1;
    localparam logic [1:0] MODE_STOPPED = 2'd2;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_LOW     = 3'd1;
    localparam logic [2:0] PH_RISING  = 3'd2;
    localparam logic [2:0] PH_HIGH    = 3'd3;
    localparam logic [2:0] PH_FALLING = 3'd4;

    localparam logic [6:0] DUTY_FULL = 7'd100;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture an input request
        logic find;      // scan step over the current device slots
        logic init;      // write the start record into the selected slot
        logic stop;      // mark the matched slot stopped
        logic tick_slot; // update the current slot for a tick
        logic div_start; // launch the shared divider
        logic show_slot; // evaluate display of the current slot
        logic emit_stat; // push the status reply
        logic next_slot; // advance the slot walk
        logic finish;    // mark the last pushed result
    } lbs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] kind;
        logic       dev_bad;
        logic       walk_done;
        logic       matched;
        logic       slots_full;
        logic       div_busy;
        logic       fifo_empty;
    } lbs_sts_t;

endpackage

// File: rtl/core/lbs_div.sv
// Radix-2 restoring divider shared by the sequencer datapath.
// Depends on lbs_pkg; one quotient bit per cycle.
module lbs_div
    import lbs_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[W-1:0], quo_reg[W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

// File: rtl/core/lbs_datapath.sv
// Datapath of the LED breathing sequencer: slot storage, tick arithmetic,
// duty computation through the shared divider and the result queue.
// Depends on lbs_pkg and lbs_div.
module lbs_datapath
    import lbs_pkg::*;
#(
    parameter int DEVICES = DEVICES_DEF,
    parameter int SLOTS   = SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  lbs_cmd_t   cmd,
    output lbs_sts_t   sts,
    input  logic [1:0] kind,
    input  logic [7:0] device,
    input  logic [7:0] sub_id,
    input  logic [15:0] low_period,
    input  logic [15:0] rise_period,
    input  logic [15:0] high_period,
    input  logic [15:0] step_period,
    input  logic [15:0] total_period,
    input  logic [31:0] current_tick,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] out_device,
    output logic [7:0] out_sub_id,
    output logic [6:0] duty,
    output logic [1:0] status,
    output logic       last
);
    localparam int DW  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNW = $clog2(SLOTS + 1);
    localparam int NS  = DEVICES * SLOTS;
    localparam int IW  = (NS > 1) ? $clog2(NS) : 1;
    localparam int QD  = MAX_RESULTS;
    localparam int QW  = $clog2(QD);

    // Captured request.
    logic [1:0]  kind_reg;
    logic [7:0]  dev_reg, sub_reg;
    logic [15:0] lowp_reg, risep_reg, highp_reg, stepp_reg, totp_reg;

    // Per-slot state, flat index dev*SLOTS+slot.
    logic [CNW-1:0] cnt_reg [DEVICES];
    logic [1:0]  mode_reg  [NS];
    logic [2:0]  ph_reg    [NS];
    logic [2:0]  shown_reg [NS];
    logic [31:0] cyc_reg   [NS];
    logic [15:0] stmr_reg  [NS];
    logic [15:0] snum_reg  [NS];
    logic [7:0]  sid_reg   [NS];
    logic [15:0] stot_reg  [NS];
    logic [15:0] plow_reg  [NS];
    logic [15:0] prise_reg [NS];
    logic [15:0] phigh_reg [NS];
    logic [15:0] pstep_reg [NS];
    logic [15:0] ptot_reg  [NS];
    logic [31:0] last_tick_reg;

    // Walk position.
    logic [DW-1:0] wdev_reg;
    logic [SW:0]   wslot_reg;
    logic          match_reg;
    logic [SW-1:0] mslot_reg;
    logic          wrap_reg;
    logic [31:0]   delta_reg;

    // Result queue.
    logic [1:0] q_kind [QD];
    logic [7:0] q_dev  [QD];
    logic [7:0] q_sub  [QD];
    logic [6:0] q_duty [QD];
    logic [1:0] q_st   [QD];
    logic       q_last [QD];
    logic [QW-1:0] q_wr_reg, q_rd_reg;
    logic [QW:0]   q_cnt_reg;
    logic [QW:0]   n_reg;
    logic [QW-1:0] last_idx_reg;

    logic [DW-1:0]  cdev;
    logic [IW-1:0]  cidx, midx, aidx;
    logic           dev_bad;
    logic [CNW-1:0] ccnt;
    logic           walk_done;

    logic        div_busy;
    logic [31:0] div_q;
    logic [31:0] div_a, div_b;

    assign dev_bad = (dev_reg >= 8'(DEVICES));
    assign cdev    = (kind_reg == KIND_TICK) ? wdev_reg : dev_reg[DW-1:0];
    assign ccnt    = cnt_reg[cdev];
    assign cidx    = IW'(cdev) * IW'(SLOTS) + IW'(wslot_reg);
    assign midx    = IW'(dev_reg[DW-1:0]) * IW'(SLOTS) + IW'(mslot_reg);
    assign aidx    = IW'(dev_reg[DW-1:0]) * IW'(SLOTS) + IW'(ccnt[SW-1:0]);
    assign walk_done = (wslot_reg >= (SW+1)'(ccnt)) || (wslot_reg >= (SW+1)'(SLOTS));

    // Divider input: step_total at start, or step*100 / total at show time.
    always_comb
    begin
        if (kind_reg == KIND_START)
        begin
            div_a = {16'd0, risep_reg};
            div_b = {16'd0, stepp_reg};
        end
        else
        begin
            div_a = {16'd0, snum_reg[cidx]} * 32'd100;
            div_b = {16'd0, stot_reg[cidx]};
        end
    end

    lbs_div #(.W(32)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Push request into the queue.
    logic       push;
    logic [1:0] p_kind;
    logic [6:0] p_duty;
    logic [1:0] p_st;
    logic [7:0] p_sub;
    logic [7:0] p_dev;
    logic [2:0] ph_c;
    logic [6:0] ramp;
    logic       pop;

    assign ph_c = ph_reg[cidx];
    assign ramp = (stot_reg[cidx] == 16'd0 || div_q > 32'd100) ? DUTY_FULL : div_q[6:0];
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        push   = 1'b0;
        p_kind = RES_STATUS;
        p_duty = '0;
        p_st   = ST_OK;
        p_sub  = sub_reg;
        p_dev  = dev_reg;
        if (cmd.emit_stat)
        begin
            push = 1'b1;
            p_st = dev_bad ? ST_BAD_DEV
                 : (kind_reg == KIND_START && !match_reg
                    && ccnt >= CNW'(SLOTS)) ? ST_FULL : ST_OK;
        end
        else if (cmd.stop && match_reg)
        begin
            push   = 1'b1;
            p_kind = RES_OFF;
        end
        else if (cmd.show_slot && ph_c != PH_IDLE && ph_c <= PH_FALLING
                 && shown_reg[cidx] != ph_c)
        begin
            push  = 1'b1;
            p_dev = 8'(wdev_reg);
            p_sub = sid_reg[cidx];
            case (ph_c)
                PH_LOW:     p_kind = RES_OFF;
                PH_HIGH:    begin p_kind = RES_DUTY; p_duty = DUTY_FULL; end
                PH_RISING:  begin p_kind = RES_DUTY; p_duty = ramp; end
                PH_FALLING: begin p_kind = RES_DUTY; p_duty = DUTY_FULL - ramp; end
                default:    p_kind = RES_OFF;
            endcase
        end
    end

    logic do_push;
    assign do_push = push && (n_reg < (QW+1)'(QD));

    // Tick arithmetic for the current slot.
    logic [31:0] c_new;
    logic [15:0] t_new, n_new;
    logic [2:0]  p_new;
    logic [31:0] lr, lrh;
    logic        fade_hit;

    always_comb
    begin
        c_new    = wrap_reg ? 32'd0 : cyc_reg[cidx] + delta_reg;
        t_new    = wrap_reg ? stmr_reg[cidx] : stmr_reg[cidx] + delta_reg[15:0];
        n_new    = snum_reg[cidx];
        p_new    = wrap_reg ? PH_IDLE : ph_reg[cidx];
        fade_hit = 1'b0;
        lr       = {16'd0, plow_reg[cidx]} + {16'd0, prise_reg[cidx]};
        lrh      = lr + {16'd0, phigh_reg[cidx]};
        if (mode_reg[cidx] == MODE_SERVING)
        begin
            if (p_new == PH_IDLE)
                p_new = PH_LOW;
            if (c_new >= {16'd0, ptot_reg[cidx]})
            begin
                p_new = PH_LOW; c_new = '0; n_new = '0; t_new = '0;
            end
            else if (c_new >= lrh)
            begin
                p_new    = PH_FALLING;
                fade_hit = 1'b1;
            end
            else if (c_new >= lr)
            begin
                p_new = PH_HIGH; n_new = '0; t_new = '0;
            end
            else if (c_new >= {16'd0, plow_reg[cidx]})
            begin
                p_new    = PH_RISING;
                fade_hit = 1'b1;
            end
        end
    end

    // A step is only taken when the fade branch itself was reached this tick.
    logic stepping;
    assign stepping = fade_hit && (t_new >= pstep_reg[cidx]);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            dev_reg   <= device;
            sub_reg   <= sub_id;
            lowp_reg  <= low_period;
            risep_reg <= rise_period;
            highp_reg <= high_period;
            stepp_reg <= step_period;
            totp_reg  <= total_period;
        end
        if (cmd.init)
        begin
            sid_reg[match_reg ? midx : aidx]   <= sub_reg;
            plow_reg[match_reg ? midx : aidx]  <= lowp_reg;
            prise_reg[match_reg ? midx : aidx] <= risep_reg;
            phigh_reg[match_reg ? midx : aidx] <= highp_reg;
            pstep_reg[match_reg ? midx : aidx] <= stepp_reg;
            ptot_reg[match_reg ? midx : aidx]  <= totp_reg;
            stot_reg[match_reg ? midx : aidx]  <=
                (stepp_reg == 16'd0) ? 16'hFFFF : div_q[15:0];
        end
        if (do_push)
        begin
            q_kind[q_wr_reg] <= p_kind;
            q_dev[q_wr_reg]  <= p_dev;
            q_sub[q_wr_reg]  <= p_sub;
            q_duty[q_wr_reg] <= p_duty;
            q_st[q_wr_reg]   <= p_st;
            q_last[q_wr_reg] <= 1'b0;
        end
        if (cmd.finish && n_reg != '0)
            q_last[last_idx_reg] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEVICES; i++)
                cnt_reg[i] <= '0;
            for (int i = 0; i < NS; i++)
            begin
                mode_reg[i]  <= MODE_IDLE;
                ph_reg[i]    <= PH_IDLE;
                shown_reg[i] <= PH_IDLE;
                cyc_reg[i]   <= '0;
                stmr_reg[i]  <= '0;
                snum_reg[i]  <= '0;
            end
            last_tick_reg <= '0;
            wdev_reg      <= '0;
            wslot_reg     <= '0;
            match_reg     <= 1'b0;
            mslot_reg     <= '0;
            wrap_reg      <= 1'b0;
            delta_reg     <= '0;
            q_wr_reg      <= '0;
            q_rd_reg      <= '0;
            q_cnt_reg     <= '0;
            n_reg         <= '0;
            last_idx_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                wdev_reg  <= '0;
                wslot_reg <= '0;
                match_reg <= 1'b0;
                n_reg     <= '0;
                wrap_reg  <= last_tick_reg > current_tick;
                delta_reg <= (last_tick_reg > current_tick) ? 32'd0
                                                            : current_tick - last_tick_reg;
                if (kind == KIND_TICK)
                    last_tick_reg <= (last_tick_reg > current_tick) ? 32'd0 : current_tick;
            end
            if (cmd.find && !walk_done && !match_reg)
            begin
                if (sid_reg[cidx] == sub_reg
                    && (mode_reg[cidx] == MODE_SERVING
                        || (kind_reg == KIND_START && mode_reg[cidx] == MODE_STOPPED)))
                begin
                    match_reg <= 1'b1;
                    mslot_reg <= wslot_reg[SW-1:0];
                end
                else
                    wslot_reg <= wslot_reg + 1'b1;
            end
            if (cmd.init)
            begin
                mode_reg[match_reg ? midx : aidx] <= MODE_SERVING;
                cyc_reg[match_reg ? midx : aidx]  <= '0;
                ph_reg[match_reg ? midx : aidx]   <= PH_IDLE;
                if (!match_reg)
                    cnt_reg[dev_reg[DW-1:0]] <= ccnt + 1'b1;
            end
            if (cmd.stop && match_reg)
                mode_reg[midx] <= MODE_STOPPED;
            if (cmd.tick_slot)
            begin
                cyc_reg[cidx]  <= c_new;
                ph_reg[cidx]   <= p_new;
                stmr_reg[cidx] <= stepping ? 16'd0 : t_new;
                snum_reg[cidx] <= stepping ? n_new + 16'd1 : n_new;
                if (stepping)
                    shown_reg[cidx] <= PH_IDLE;
            end
            if (cmd.show_slot && push)
                shown_reg[cidx] <= ph_c;
            if (cmd.next_slot)
            begin
                if (walk_done)
                begin
                    wslot_reg <= '0;
                    wdev_reg  <= wdev_reg + 1'b1;
                end
                else
                    wslot_reg <= wslot_reg + 1'b1;
            end
            if (do_push)
            begin
                q_wr_reg     <= q_wr_reg + 1'b1;
                last_idx_reg <= q_wr_reg;
                n_reg        <= n_reg + 1'b1;
            end
            q_cnt_reg <= q_cnt_reg + (QW+1)'(do_push) - (QW+1)'(pop);
            if (pop)
                q_rd_reg <= q_rd_reg + 1'b1;
        end
    end

    // A result only leaves once its item is finished, so last is settled.
    logic [QW:0]  ready_cnt_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ready_cnt_reg <= '0;
        else
            ready_cnt_reg <= ready_cnt_reg + (cmd.finish ? n_reg : '0) - (QW+1)'(pop);
    end

    assign out_valid   = (ready_cnt_reg != '0);
    assign result_kind = q_kind[q_rd_reg];
    assign out_device  = q_dev[q_rd_reg];
    assign out_sub_id  = q_sub[q_rd_reg];
    assign duty        = q_duty[q_rd_reg];
    assign status      = q_st[q_rd_reg];
    assign last        = q_last[q_rd_reg];

    assign sts.kind       = kind_reg;
    assign sts.dev_bad    = dev_bad;
    assign sts.walk_done  = walk_done;
    assign sts.matched    = match_reg;
    assign sts.slots_full = (ccnt >= CNW'(SLOTS));
    assign sts.div_busy   = div_busy;
    assign sts.fifo_empty = (q_cnt_reg == '0);

    assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg <= (QW+1)'(QD))
        else $error("result queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        ready_cnt_reg <= q_cnt_reg)
        else $error("released results exceed queued results");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> div_busy)
        else $error("divider did not start");
endmodule

// File: rtl/core/lbs_ctrl.sv
// Controller of the LED breathing sequencer: sequences each request through
// the datapath. Depends on lbs_pkg.
module lbs_ctrl
    import lbs_pkg::*;
#(
    parameter int DEVICES = DEVICES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  lbs_sts_t sts,
    output lbs_cmd_t cmd
);
    localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DISP  = 10'b0000000010,
        S_FIND  = 10'b0000000100,
        S_DIVW  = 10'b0000001000,
        S_INIT  = 10'b0000010000,
        S_STAT  = 10'b0000100000,
        S_TSLOT = 10'b0001000000,
        S_TDIV  = 10'b0010000000,
        S_TSHOW = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [DW:0] dev_reg, dev_next;

    always_comb
    begin
        state_next = state_reg;
        dev_next   = dev_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = sts.fifo_empty;
                if (in_valid && sts.fifo_empty)
                begin
                    cmd.load   = 1'b1;
                    dev_next   = '0;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.kind == KIND_TICK)
                    state_next = S_TSLOT;
                else if (sts.kind == KIND_START || sts.kind == KIND_STOP)
                    state_next = sts.dev_bad ? S_STAT : S_FIND;
                else
                    state_next = S_DONE;
            end
            S_FIND:
            begin
                cmd.find = 1'b1;
                if (sts.matched || sts.walk_done)
                begin
                    cmd.find = 1'b0;
                    if (sts.kind == KIND_STOP)
                    begin
                        cmd.stop   = 1'b1;
                        state_next = S_STAT;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIVW;
                    end
                end
            end
            S_DIVW:
            begin
                if (!sts.div_busy)
                    state_next = S_INIT;
            end
            S_INIT:
            begin
                // A full device gets no new slot; the status says so.
                cmd.emit_stat = 1'b1;
                cmd.init      = sts.matched || !sts.slots_full;
                state_next    = S_DONE;
            end
            S_STAT:
            begin
                cmd.emit_stat = 1'b1;
                state_next    = S_DONE;
            end
            S_TSLOT:
            begin
                if (dev_reg >= (DW+1)'(DEVICES))
                    state_next = S_DONE;
                else if (sts.walk_done)
                begin
                    cmd.next_slot = 1'b1;
                    dev_next      = dev_reg + 1'b1;
                end
                else
                begin
                    cmd.tick_slot = 1'b1;
                    state_next    = S_TDIV;
                end
            end
            S_TDIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_TSHOW;
            end
            S_TSHOW:
            begin
                if (!sts.div_busy)
                begin
                    cmd.show_slot = 1'b1;
                    cmd.next_slot = 1'b1;
                    state_next    = S_TSLOT;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dev_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dev_reg   <= dev_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("request taken outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> state_reg == S_IDLE)
        else $error("finish did not return to idle");
endmodule

// File: rtl/core/led_breathing_sequencer_top.sv
// Top level of the LED breathing sequencer: joins controller and datapath.
// Depends on lbs_pkg, lbs_ctrl, lbs_datapath and lbs_div.
//
// Usage: one input channel (in_valid/in_ready) carries tick, start and stop
// requests; one output channel (out_valid/out_ready) carries result items,
// with last set on the final result caused by a request.
// A start request runs the search over the device's slots and a wait on the
// step_total division in the shared divider. A stop runs the same search.
// A tick walks every allocated slot of every device; each slot waits on
// the duty division in the shared divider.
// Results are queued (up to eight per request) and are released once the
// request is finished; the next request is accepted once the queue drained,
// so a stalling receiver holds the block in idle with in_ready low.
// Reset clears the slot counts, each slot's mode, phase and timers, the tick
// reference and the result queue pointers; no clearing pass is needed.
module led_breathing_sequencer_top
    import lbs_pkg::*;
#(
    parameter int DEVICES = DEVICES_DEF,
    parameter int SLOTS   = SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  device,
    input  logic [7:0]  sub_id,
    input  logic [15:0] low_period,
    input  logic [15:0] rise_period,
    input  logic [15:0] high_period,
    input  logic [15:0] step_period,
    input  logic [15:0] total_period,
    input  logic [31:0] current_tick,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [7:0]  out_device,
    output logic [7:0]  out_sub_id,
    output logic [6:0]  duty,
    output logic [1:0]  status,
    output logic        last
);
    lbs_cmd_t cmd;
    lbs_sts_t sts;

    lbs_ctrl #(.DEVICES(DEVICES)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lbs_datapath #(.DEVICES(DEVICES), .SLOTS(SLOTS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .kind         (kind),
        .device       (device),
        .sub_id       (sub_id),
        .low_period   (low_period),
        .rise_period  (rise_period),
        .high_period  (high_period),
        .step_period  (step_period),
        .total_period (total_period),
        .current_tick (current_tick),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .out_device   (out_device),
        .out_sub_id   (out_sub_id),
        .duty         (duty),
        .status       (status),
        .last         (last)
    );
endmodule
